// ----- hdl/msgp_pkg.sv -----
`default_nettype none

package msgp_pkg;

  // Token kinds carried on the kind input
  typedef enum logic [3:0] {
    KindNil   = 4'd0,
    KindBool  = 4'd1,
    KindUint  = 4'd2,
    KindInt   = 4'd3,
    KindF32   = 4'd4,
    KindF64   = 4'd5,
    KindStr   = 4'd6,
    KindArray = 4'd7,
    KindMap   = 4'd8,
    KindRaw   = 4'd9
  } kind_e;

  localparam int unsigned MaxBytes  = 9;
  localparam int unsigned SeqWidth  = 8 * MaxBytes;
  localparam int unsigned LenWidth  = $clog2(MaxBytes + 1);

  // Format bytes
  localparam logic [7:0] HdrNil      = 8'hc0;
  localparam logic [7:0] HdrFalse    = 8'hc2;
  localparam logic [7:0] HdrTrue     = 8'hc3;
  localparam logic [7:0] HdrF32      = 8'hca;
  localparam logic [7:0] HdrF64      = 8'hcb;
  localparam logic [7:0] HdrU8       = 8'hcc;
  localparam logic [7:0] HdrU16      = 8'hcd;
  localparam logic [7:0] HdrU32      = 8'hce;
  localparam logic [7:0] HdrU64      = 8'hcf;
  localparam logic [7:0] HdrI8       = 8'hd0;
  localparam logic [7:0] HdrI16      = 8'hd1;
  localparam logic [7:0] HdrI32      = 8'hd2;
  localparam logic [7:0] HdrI64      = 8'hd3;
  localparam logic [7:0] HdrStr8     = 8'hd9;
  localparam logic [7:0] HdrStr16    = 8'hda;
  localparam logic [7:0] HdrStr32    = 8'hdb;
  localparam logic [7:0] HdrArray16  = 8'hdc;
  localparam logic [7:0] HdrArray32  = 8'hdd;
  localparam logic [7:0] HdrMap16    = 8'hde;
  localparam logic [7:0] HdrMap32    = 8'hdf;
  localparam logic [7:0] HdrFixStr   = 8'ha0;
  localparam logic [7:0] HdrFixArray = 8'h90;
  localparam logic [7:0] HdrFixMap   = 8'h80;

  // Encoded token: byte sequence with the first wire byte in the low bits
  typedef struct packed {
    logic [SeqWidth-1:0] seq;
    logic [LenWidth-1:0] len;
  } enc_t;

endpackage

`default_nettype wire

// ----- hdl/msgp_enc.sv -----
`default_nettype none

module msgp_enc (
  input  wire logic [3:0]  kind_i,
  input  wire logic [63:0] value_i,
  output msgp_pkg::enc_t   enc_o
);

  logic [7:0]  hdr;
  logic [3:0]  nb;
  logic        none;
  logic [63:0] aligned;
  logic [63:0] payload;

  // Pick the format byte and the payload width
  always_comb begin
    hdr  = msgp_pkg::HdrNil;
    nb   = 4'd0;
    none = 1'b0;
    case (msgp_pkg::kind_e'(kind_i))
      msgp_pkg::KindNil: begin
        hdr = msgp_pkg::HdrNil;
      end
      msgp_pkg::KindBool: begin
        hdr = (value_i != 64'd0) ? msgp_pkg::HdrTrue : msgp_pkg::HdrFalse;
      end
      msgp_pkg::KindUint, msgp_pkg::KindInt: begin
        if (value_i[63] && msgp_pkg::kind_e'(kind_i) == msgp_pkg::KindInt) begin
          if (&value_i[63:5]) begin
            hdr = value_i[7:0];
          end else if (&value_i[63:7]) begin
            hdr = msgp_pkg::HdrI8;  nb = 4'd1;
          end else if (&value_i[63:15]) begin
            hdr = msgp_pkg::HdrI16; nb = 4'd2;
          end else if (&value_i[63:31]) begin
            hdr = msgp_pkg::HdrI32; nb = 4'd4;
          end else begin
            hdr = msgp_pkg::HdrI64; nb = 4'd8;
          end
        end else begin
          if (value_i[63:7] == '0) begin
            hdr = value_i[7:0];
          end else if (value_i[63:8] == '0) begin
            hdr = msgp_pkg::HdrU8;  nb = 4'd1;
          end else if (value_i[63:16] == '0) begin
            hdr = msgp_pkg::HdrU16; nb = 4'd2;
          end else if (value_i[63:32] == '0) begin
            hdr = msgp_pkg::HdrU32; nb = 4'd4;
          end else begin
            hdr = msgp_pkg::HdrU64; nb = 4'd8;
          end
        end
      end
      msgp_pkg::KindF32: begin
        hdr = msgp_pkg::HdrF32; nb = 4'd4;
      end
      msgp_pkg::KindF64: begin
        hdr = msgp_pkg::HdrF64; nb = 4'd8;
      end
      msgp_pkg::KindStr: begin
        if (value_i[63:5] == '0) begin
          hdr = msgp_pkg::HdrFixStr | {3'b000, value_i[4:0]};
        end else if (value_i[63:8] == '0) begin
          hdr = msgp_pkg::HdrStr8;  nb = 4'd1;
        end else if (value_i[63:16] == '0) begin
          hdr = msgp_pkg::HdrStr16; nb = 4'd2;
        end else begin
          hdr = msgp_pkg::HdrStr32; nb = 4'd4;
        end
      end
      msgp_pkg::KindArray, msgp_pkg::KindMap: begin
        if (value_i[63:4] == '0) begin
          hdr = ((msgp_pkg::kind_e'(kind_i) == msgp_pkg::KindMap) ?
                 msgp_pkg::HdrFixMap : msgp_pkg::HdrFixArray) | {4'h0, value_i[3:0]};
        end else if (value_i[63:16] == '0) begin
          hdr = (msgp_pkg::kind_e'(kind_i) == msgp_pkg::KindMap) ?
                msgp_pkg::HdrMap16 : msgp_pkg::HdrArray16;
          nb  = 4'd2;
        end else begin
          hdr = (msgp_pkg::kind_e'(kind_i) == msgp_pkg::KindMap) ?
                msgp_pkg::HdrMap32 : msgp_pkg::HdrArray32;
          nb  = 4'd4;
        end
      end
      msgp_pkg::KindRaw: begin
        hdr = value_i[7:0];
      end
      default: begin
        none = 1'b1;
      end
    endcase
  end

  // Move the payload bytes to the top, then swap so the most significant
  // payload byte comes out first
  assign aligned = (nb == 4'd0) ? 64'd0 : (value_i << {(4'd8 - nb), 3'b000});

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      payload[8*i +: 8] = aligned[8*(7-i) +: 8];
    end
  end

  assign enc_o.seq = {payload, hdr};
  assign enc_o.len = none ? '0 : msgp_pkg::LenWidth'(nb + 4'd1);

endmodule

`default_nettype wire

// ----- hdl/msgpack_value_encoder.sv -----
`default_nettype none

// Channel  Direction  Handshake               Payload
// in       request    in_valid_i/in_stall_o   kind_i[3:0], value_i[63:0]
// out      result     out_valid_o/out_stall_i out_byte_o[7:0], last_o
//
// A token waits in the input register, then loads into the byte shifter, which
// sends one byte per cycle while out_stall_i is low: a token takes 1 to 9 bytes
// on the output, set by its encoded length; the next token loads in the cycle
// its predecessor's last byte leaves. Unused kinds are accepted and dropped.
// Reset clears the input and shifter occupancy; payload registers keep junk.
// out_stall_i holds the shifter; a full input register that cannot load in
// this cycle raises in_stall_o.
module msgpack_value_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  kind_i,
  input  wire logic [63:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);

  // Input register
  logic        in_full_q, in_full_d;
  logic [3:0]  kind_q;
  logic [63:0] value_q;

  // Byte shifter: first pending byte in the low bits
  logic [msgp_pkg::SeqWidth-1:0] seq_q, seq_d;
  logic [msgp_pkg::LenWidth-1:0] cnt_q, cnt_d;

  msgp_pkg::enc_t enc;

  logic in_take;
  logic out_take;
  logic load;

  msgp_enc u_enc (
    .kind_i  (kind_q),
    .value_i (value_q),
    .enc_o   (enc)
  );

  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = seq_q[7:0];
  assign last_o      = (cnt_q == msgp_pkg::LenWidth'(1));
  assign out_take    = out_valid_o && !out_stall_i;

  // Load the next token when the shifter is empty or its last byte leaves now
  assign load       = in_full_q && (!out_valid_o || (last_o && out_take));
  assign in_stall_o = in_full_q && !load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_full_d = in_full_q;
    if (in_take) begin
      in_full_d = 1'b1;
    end else if (load) begin
      in_full_d = 1'b0;
    end
  end

  always_comb begin
    seq_d = seq_q;
    cnt_d = cnt_q;
    if (load) begin
      seq_d = enc.seq;
      cnt_d = enc.len;
    end else if (out_take) begin
      seq_d = seq_q >> 8;
      cnt_d = cnt_q - msgp_pkg::LenWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      in_full_q <= in_full_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
    seq_q <= seq_d;
  end

  // Shifter never holds more than one full token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= msgp_pkg::LenWidth'(msgp_pkg::MaxBytes))
    else $error("byte count above maximum token length");

  // An accepted request lands in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_full_q)
    else $error("accepted request lost");

  // A held token is not dropped while the shifter is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_full_q && in_stall_o) |=> (in_full_q && $stable(kind_q) && $stable(value_q)))
    else $error("held token changed or dropped");

  // Each sent byte that is not the last one lowers the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !last_o) |=> (cnt_q == $past(cnt_q) - msgp_pkg::LenWidth'(1)))
    else $error("byte count skipped");

endmodule

`default_nettype wire

// ----- tb/msgpack_value_encoder_test.sv -----
`timescale 1ns / 1ps

module msgpack_value_encoder_test;

  // Highest kind code; everything above KindRaw is dropped by the block
  localparam logic [3:0] KindUnusedTop = 4'hf;

  // Encoded token: count bytes, right-aligned in seq, first wire byte leftmost
  typedef struct packed {
    logic [3:0]  count;
    logic [71:0] seq;
  } token_enc_t;

  // One byte as it must appear on the result channel
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } wire_byte_t;

  // Directed row: when fixed is set, count/seq are the literal encoding,
  // otherwise the row goes through the encoder model
  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic        fixed;
    logic [3:0]  count;
    logic [71:0] seq;
  } stim_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [3:0]  kind_i      = 4'd0;
  logic [63:0] value_i     = 64'd0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        last_o;

  // Encodings owed per request, in request order, and the bytes owed on the wire
  token_enc_t tokens_q [$];
  wire_byte_t wire_bytes_q [$];

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_checked  = 0;
  int unsigned tokens_sent    = 0;
  int unsigned tokens_dropped = 0;

  int unsigned idle_mix  [4] = '{0, 85, 0, 21};
  int unsigned stall_mix [4] = '{0, 0, 85, 21};

  stim_row_t directed_rows [27] = '{
    '{msgp_pkg::KindNil,   64'h0,                   1'b1, 4'd1, 72'hc0},
    '{msgp_pkg::KindBool,  64'h0,                   1'b1, 4'd1, 72'hc2},
    '{msgp_pkg::KindBool,  64'h8000_0000_0000_0000, 1'b1, 4'd1, 72'hc3},
    '{msgp_pkg::KindUint,  64'h7f,                  1'b1, 4'd1, 72'h7f},
    '{msgp_pkg::KindUint,  64'h80,                  1'b1, 4'd2, 72'hcc80},
    '{msgp_pkg::KindUint,  64'hffff_ffff,           1'b1, 4'd5, 72'hce_ffff_ffff},
    '{msgp_pkg::KindUint,  64'hffff_ffff_ffff_ffff, 1'b1, 4'd9,
      72'hcf_ffff_ffff_ffff_ffff},
    '{msgp_pkg::KindUint,  64'h0123_4567_89ab_cdef, 1'b0, 4'd0, 72'h0},
    '{msgp_pkg::KindInt,   64'hffff_ffff_ffff_ffff, 1'b1, 4'd1, 72'hff},
    '{msgp_pkg::KindInt,   64'hffff_ffff_ffff_ffe0, 1'b1, 4'd1, 72'he0},
    '{msgp_pkg::KindInt,   64'hffff_ffff_ffff_ffdf, 1'b1, 4'd2, 72'hd0df},
    '{msgp_pkg::KindInt,   64'hffff_ffff_ffff_8000, 1'b1, 4'd3, 72'hd1_8000},
    '{msgp_pkg::KindInt,   64'h8000_0000_0000_0000, 1'b1, 4'd9,
      72'hd3_8000_0000_0000_0000},
    '{msgp_pkg::KindInt,   64'h7fff_ffff_ffff_ffff, 1'b1, 4'd9,
      72'hcf_7fff_ffff_ffff_ffff},
    '{msgp_pkg::KindInt,   64'hffff_ffff_fedc_ba98, 1'b0, 4'd0, 72'h0},
    '{msgp_pkg::KindF32,   64'hdead_beef_3f80_0000, 1'b1, 4'd5, 72'hca_3f80_0000},
    '{msgp_pkg::KindF64,   64'h3ff0_0000_0000_0000, 1'b1, 4'd9,
      72'hcb_3ff0_0000_0000_0000},
    '{msgp_pkg::KindStr,   64'd31,                  1'b1, 4'd1, 72'hbf},
    '{msgp_pkg::KindStr,   64'd32,                  1'b1, 4'd2, 72'hd920},
    '{msgp_pkg::KindStr,   64'd300,                 1'b0, 4'd0, 72'h0},
    // length wider than 32 bits: 32-bit form, upper half dropped
    '{msgp_pkg::KindStr,   64'h1_0000_0005,         1'b1, 4'd5, 72'hdb_0000_0005},
    '{msgp_pkg::KindArray, 64'd15,                  1'b1, 4'd1, 72'h9f},
    '{msgp_pkg::KindArray, 64'd16,                  1'b1, 4'd3, 72'hdc_0010},
    '{msgp_pkg::KindArray, 64'hffff_ffff_ffff_ffff, 1'b1, 4'd5, 72'hdd_ffff_ffff},
    '{msgp_pkg::KindMap,   64'h0,                   1'b1, 4'd1, 72'h80},
    '{msgp_pkg::KindRaw,   64'hffff_ffff_ffff_ffa5, 1'b1, 4'd1, 72'ha5},
    // unused kind: accepted, nothing comes out
    '{KindUnusedTop, 64'hffff_ffff_ffff_ffff, 1'b1, 4'd0, 72'h0}
  };

  msgpack_value_encoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  always begin
    #6ns clk_i = 1'b1;
    #6ns clk_i = 1'b0;
  end

  // Encoder model: pick a format byte and a big-endian payload length, then
  // pack the format byte above the low plen bytes of the value
  function automatic token_enc_t encode_token(input logic [3:0] kind,
                                              input logic [63:0] v);
    token_enc_t  enc;
    logic [7:0]  hdr;
    int unsigned plen;
    logic [71:0] mask;
    hdr  = 8'h00;
    plen = 0;
    enc.count = 4'd1;
    case (kind)
      msgp_pkg::KindNil:  hdr = msgp_pkg::HdrNil;
      msgp_pkg::KindBool: hdr = (v != 64'd0) ? msgp_pkg::HdrTrue : msgp_pkg::HdrFalse;
      msgp_pkg::KindUint, msgp_pkg::KindInt: begin
        if (kind == msgp_pkg::KindInt && v[63]) begin
          // negative: compare against the two's complement thresholds
          if (v >= 64'hffff_ffff_ffff_ffe0) hdr = v[7:0];
          else if (v >= 64'hffff_ffff_ffff_ff80) begin
            hdr = msgp_pkg::HdrI8;  plen = 1;
          end else if (v >= 64'hffff_ffff_ffff_8000) begin
            hdr = msgp_pkg::HdrI16; plen = 2;
          end else if (v >= 64'hffff_ffff_8000_0000) begin
            hdr = msgp_pkg::HdrI32; plen = 4;
          end else begin
            hdr = msgp_pkg::HdrI64; plen = 8;
          end
        end else begin
          if (v <= 64'h7f) hdr = v[7:0];
          else if (v <= 64'hff) begin hdr = msgp_pkg::HdrU8; plen = 1; end
          else if (v <= 64'hffff) begin hdr = msgp_pkg::HdrU16; plen = 2; end
          else if (v <= 64'hffff_ffff) begin hdr = msgp_pkg::HdrU32; plen = 4; end
          else begin hdr = msgp_pkg::HdrU64; plen = 8; end
        end
      end
      msgp_pkg::KindF32: begin hdr = msgp_pkg::HdrF32; plen = 4; end
      msgp_pkg::KindF64: begin hdr = msgp_pkg::HdrF64; plen = 8; end
      msgp_pkg::KindStr: begin
        if (v <= 64'd31) hdr = msgp_pkg::HdrFixStr | v[7:0];
        else if (v <= 64'hff) begin hdr = msgp_pkg::HdrStr8; plen = 1; end
        else if (v <= 64'hffff) begin hdr = msgp_pkg::HdrStr16; plen = 2; end
        else begin hdr = msgp_pkg::HdrStr32; plen = 4; end
      end
      msgp_pkg::KindArray: begin
        if (v <= 64'd15) hdr = msgp_pkg::HdrFixArray | v[7:0];
        else if (v <= 64'hffff) begin hdr = msgp_pkg::HdrArray16; plen = 2; end
        else begin hdr = msgp_pkg::HdrArray32; plen = 4; end
      end
      msgp_pkg::KindMap: begin
        if (v <= 64'd15) hdr = msgp_pkg::HdrFixMap | v[7:0];
        else if (v <= 64'hffff) begin hdr = msgp_pkg::HdrMap16; plen = 2; end
        else begin hdr = msgp_pkg::HdrMap32; plen = 4; end
      end
      msgp_pkg::KindRaw: hdr = v[7:0];
      default: enc.count = 4'd0;
    endcase
    mask = (72'd1 << (8 * plen)) - 72'd1;
    if (enc.count != 4'd0) enc.count = 4'(1 + plen);
    enc.seq = ({64'd0, hdr} << (8 * plen)) | ({8'd0, v} & mask);
    return enc;
  endfunction

  // Hold the request after a random number of idle cycles, then wait for
  // the block to take it; return on the accepting edge
  task automatic send_token(input logic [3:0] kind, input logic [63:0] value,
                            input token_enc_t owed);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    tokens_q = {tokens_q, owed};
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tokens_sent++;
    if (owed.count == 4'd0) tokens_dropped++;
  endtask

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Check every byte taken from the block against the oldest one owed, then
  // expand each accepted request into the bytes it owes. Sampling at the edge
  // sees the values from before the edge, so the order of processes is moot.
  always @(posedge clk_i) begin : scoreboard
    wire_byte_t want;
    token_enc_t tok;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        bytes_checked++;
        if (wire_bytes_q.size() == 0) begin
          $error("out_byte: nothing owed, got %02h (last %0b)", out_byte_o, last_o);
          mismatch_count++;
        end else begin
          want = wire_bytes_q.pop_front();
          if (out_byte_o !== want.value) begin
            $error("out_byte: expected %02h, got %02h", want.value, out_byte_o);
            mismatch_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
        tok = tokens_q.pop_front();
        for (int i = 0; i < int'(tok.count); i++) begin
          want.value = tok.seq[8 * (int'(tok.count) - 1 - i) +: 8];
          want.last  = (i == int'(tok.count) - 1);
          wire_bytes_q = {wire_bytes_q, want};
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    token_enc_t  owed;
    logic [3:0]  kind;
    logic [63:0] value;
    logic [63:0] raw;
    int unsigned counted;
    int unsigned drain;
    int unsigned leftover;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: back to back, no back-pressure; literal rows bypass the model
    foreach (directed_rows[i]) begin
      row  = directed_rows[i];
      owed = encode_token(row.kind, row.value);
      if (row.fixed) owed = '{count: row.count, seq: row.seq};
      send_token(row.kind, row.value, owed);
    end

    // Random: one block of tokens per idle/stall mix
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_mix[phase];
      stall_pct = stall_mix[phase];
      counted   = 0;
      while (counted < 80) begin
        if ($urandom_range(19) == 0) begin
          kind = 4'($urandom_range(15, int'(msgp_pkg::KindRaw) + 1));
        end else begin
          kind = 4'($urandom_range(int'(msgp_pkg::KindRaw)));
        end
        raw = {$urandom, $urandom};
        // mix full-width, short positive, short negative and near-power-of-two
        // values so every length form of every kind turns up
        case ($urandom_range(3))
          0: value = raw;
          1: value = raw >> $urandom_range(64);
          2: value = ~(raw >> $urandom_range(64));
          default: begin
            value = (64'd1 << $urandom_range(63)) - 64'd1 + 64'($urandom_range(1));
            if ($urandom_range(1) == 1) value = -value;
          end
        endcase
        owed = encode_token(kind, value);
        send_token(kind, value, owed);
        if (owed.count != 4'd0) counted++;
      end
    end

    // Drain: drop the request, release the receiver, wait out the owed bytes
    in_valid_i <= 1'b0;
    stall_pct = 0;
    drain = 0;
    while ((tokens_q.size() != 0 || wire_bytes_q.size() != 0) && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (24) @(posedge clk_i);

    leftover = tokens_q.size() + wire_bytes_q.size();
    if (leftover != 0) $error("%0d bytes or requests still owed at end of run", leftover);

    $display("Sent %0d tokens (%0d of unused kind) over four idle/stall mixes;",
             tokens_sent, tokens_dropped);
    $display("compared %0d encoded bytes, %0d mismatches.", bytes_checked, mismatch_count);
    if (mismatch_count == 0 && leftover == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
